// File: rtl/core/ptfp_pkg.sv
// Shared constants for the pan/tilt-from-position block: CORDIC arctangent table and gain data.
`default_nettype none

package ptfp_pkg;

  // Coordinates carry this many fraction guard bits inside the CORDIC datapath
  localparam int GUARD_BITS = 16;

  // Number of entries in the arctangent table (upper bound on CORDIC steps)
  localparam int ATAN_LEN = 24;

  // Mount height after reset: 0.5 m in Q8.16
  localparam int HEIGHT_RESET = 32768;

  // Gain compensation 1/K as an unsigned Q0.32 fraction, truncated
  localparam logic [31:0] INV_GAIN = 32'd2608131496;

  // The magnitude is split at this bit for the two partial products
  localparam int GAIN_SPLIT = 22;

  // Final right shift of the compensated magnitude
  localparam int GAIN_SHIFT = 10;

  // Width of the angle accumulator (fraction of a full turn)
  localparam int ACC_W = 32;

  typedef logic [ACC_W-1:0] turn_t;

  // Half turn preload for the left half plane
  localparam turn_t HALF_TURN = 32'h8000_0000;

  // round(atan(2^-i) * 2^32 / (2*pi))
  localparam turn_t ATAN_TURNS [ATAN_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

endpackage

`default_nettype wire

// File: rtl/core/pan_tilt_from_position.sv
// Top level: pipelined pan/tilt angles from a target position, two CORDIC vectoring passes.
//
// Takes one position beat (x, y, z in signed Q8.16) per cycle while in_tready is high, and
// returns pan = atan2(y, x) and tilt = atan2(z - mount_height, |xy|) as signed binary
// angles (2^(ANGLE_WIDTH-1) is pi). Every stage is one CORDIC iteration or one arithmetic
// step, and the block sustains one beat per clock while in_tready is high. The chain is:
// input conditioning, CORDIC_STEPS stages on (x, y), a stage of two partial-product
// multipliers for gain compensation, the gain sum, CORDIC_STEPS stages on (|xy|, dz),
// rounding and clamp. A two-entry output buffer decouples the chain from the consumer;
// in_tready is a register output and drops only while a result waits in the second entry.
// mount_height is written through the cfg port; writes are taken at any time but should
// only be issued while no beats are in flight.
`default_nettype none

module pan_tilt_from_position #(
  parameter int COORD_WIDTH  = 24,
  parameter int ANGLE_WIDTH  = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  // Configuration write channel: mount_height
  input  wire logic                                       cfg_valid,
  output logic                                            cfg_ready,
  input  wire logic [COORD_WIDTH-1:0]                     cfg_data,
  // Input stream
  input  wire logic                                       in_tvalid,
  output logic                                            in_tready,
  // in_tdata: pos_x, pos_y, pos_z (lowest bits first), zero padded to bytes
  input  wire logic [8*((3*COORD_WIDTH+7)/8)-1:0]         in_tdata,
  // Result stream
  output logic                                            out_tvalid,
  input  wire logic                                       out_tready,
  // out_tdata: pan_angle, tilt_angle (lowest bits first), zero padded to bytes
  output logic [8*((2*ANGLE_WIDTH+7)/8)-1:0]              out_tdata
);

  import ptfp_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int AW     = ANGLE_WIDTH;
  localparam int NS     = CORDIC_STEPS;
  localparam int OUT_W  = 8*((2*AW+7)/8);
  // Datapath width: guard bits plus headroom for sqrt(3) * CORDIC gain
  localparam int V_W    = CW + GUARD_BITS + 3;
  // Height register holds the reset value even for narrow coordinates
  localparam int HGT_W  = (CW >= 17) ? CW : 17;
  localparam int SH     = ACC_W - AW;
  localparam int HI_W   = V_W - GAIN_SPLIT;
  localparam int PA_W   = HI_W + ACC_W;
  localparam int PB_W   = GAIN_SPLIT + ACC_W;
  localparam int SUM_W  = PA_W + 1;

  typedef logic signed [V_W-1:0] vec_t;

  // --------------------------------------------------------------------------
  // Configuration register
  logic signed [HGT_W-1:0] height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= HGT_W'(HEIGHT_RESET);
    end else if (cfg_valid) begin
      height_r <= HGT_W'($signed(cfg_data));
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: stalls only while the second output entry is occupied
  logic en;
  logic skid_vld_r;

  assign en        = !skid_vld_r;
  assign in_tready = en;

  // --------------------------------------------------------------------------
  // Input conditioning: scale, fold the left half plane, saturate z - height
  logic signed [CW-1:0]             in_x, in_y, in_z;
  logic signed [CW+GUARD_BITS-1:0]  in_xs, in_ys;
  logic signed [HGT_W:0]            dz_full;
  logic [HGT_W-CW+1:0]              dz_top;
  logic signed [CW-1:0]             dz_sat;
  vec_t                             vx_in, vy_in;
  turn_t                            acc_in;

  always_comb begin
    in_x    = in_tdata[CW-1:0];
    in_y    = in_tdata[2*CW-1:CW];
    in_z    = in_tdata[3*CW-1:2*CW];
    in_xs   = {in_x, {GUARD_BITS{1'b0}}};
    in_ys   = {in_y, {GUARD_BITS{1'b0}}};
    dz_full = (HGT_W+1)'(in_z) - (HGT_W+1)'(height_r);
    dz_top  = dz_full[HGT_W:CW-1];
    if ((&dz_top) || !(|dz_top)) begin
      dz_sat = dz_full[CW-1:0];
    end else if (dz_full[HGT_W]) begin
      dz_sat = {1'b1, {(CW-1){1'b0}}};
    end else begin
      dz_sat = {1'b0, {(CW-1){1'b1}}};
    end
    if (in_x[CW-1]) begin
      vx_in  = -V_W'(in_xs);
      vy_in  = -V_W'(in_ys);
      acc_in = HALF_TURN;
    end else begin
      vx_in  = V_W'(in_xs);
      vy_in  = V_W'(in_ys);
      acc_in = '0;
    end
  end

  // --------------------------------------------------------------------------
  // First CORDIC pass on (x, y)
  vec_t                 p1_x_r   [NS+1];
  vec_t                 p1_y_r   [NS+1];
  turn_t                p1_acc_r [NS+1];
  logic signed [CW-1:0] p1_dz_r  [NS+1];
  logic                 p1_nz_r  [NS+1];
  logic                 p1_vld_r [NS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r[0] <= 1'b0;
    end else if (en) begin
      p1_vld_r[0] <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_x_r[0]   <= vx_in;
      p1_y_r[0]   <= vy_in;
      p1_acc_r[0] <= acc_in;
      p1_dz_r[0]  <= dz_sat;
      p1_nz_r[0]  <= (|in_x) || (|in_y);
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_pass1
    vec_t  x_nxt, y_nxt;
    turn_t acc_nxt;

    // One vectoring iteration: rotate toward the positive x axis
    always_comb begin
      if (!p1_y_r[k][V_W-1]) begin
        x_nxt   = p1_x_r[k] + (p1_y_r[k] >>> k);
        y_nxt   = p1_y_r[k] - (p1_x_r[k] >>> k);
        acc_nxt = p1_acc_r[k] + ATAN_TURNS[k];
      end else begin
        x_nxt   = p1_x_r[k] - (p1_y_r[k] >>> k);
        y_nxt   = p1_y_r[k] + (p1_x_r[k] >>> k);
        acc_nxt = p1_acc_r[k] - ATAN_TURNS[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        p1_vld_r[k+1] <= 1'b0;
      end else if (en) begin
        p1_vld_r[k+1] <= p1_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p1_x_r[k+1]   <= x_nxt;
        p1_y_r[k+1]   <= y_nxt;
        p1_acc_r[k+1] <= acc_nxt;
        p1_dz_r[k+1]  <= p1_dz_r[k];
        p1_nz_r[k+1]  <= p1_nz_r[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Gain compensation partial products and pan rounding
  logic [HI_W-1:0]       mag_hi;
  logic [GAIN_SPLIT-1:0] mag_lo;
  logic [ACC_W:0]        pan_sum;
  logic [AW-1:0]         pan_nxt;

  logic [PA_W-1:0]       prod_a_r;
  logic [PB_W-1:0]       prod_b_r;
  logic [AW-1:0]         m_pan_r;
  logic signed [CW-1:0]  m_dz_r;
  logic                  m_nz_r;
  logic                  m_vld_r;

  always_comb begin
    // Negative magnitude cannot occur in practice; it is treated as zero
    if (p1_x_r[NS][V_W-1]) begin
      mag_hi = '0;
      mag_lo = '0;
    end else begin
      mag_hi = p1_x_r[NS][V_W-1:GAIN_SPLIT];
      mag_lo = p1_x_r[NS][GAIN_SPLIT-1:0];
    end
    // Round to nearest (add half, floor); a carry past the top wraps to -pi
    pan_sum = {p1_acc_r[NS][ACC_W-1], p1_acc_r[NS]} + ((ACC_W+1)'(1) << (SH-1));
    pan_nxt = p1_nz_r[NS] ? pan_sum[SH+AW-1:SH] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (en) begin
      m_vld_r <= p1_vld_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_a_r <= PA_W'(mag_hi) * PA_W'(INV_GAIN);
      prod_b_r <= PB_W'(mag_lo) * PB_W'(INV_GAIN);
      m_pan_r  <= pan_nxt;
      m_dz_r   <= p1_dz_r[NS];
      m_nz_r   <= p1_nz_r[NS];
    end
  end

  // --------------------------------------------------------------------------
  // Gain sum, magnitude, and setup of the second pass
  logic [SUM_W-1:0]                gain_sum;
  vec_t                            mag;
  logic signed [CW+GUARD_BITS-1:0] dz_s;

  always_comb begin
    gain_sum = SUM_W'(prod_a_r) + SUM_W'(prod_b_r >> GAIN_SPLIT);
    mag      = m_nz_r ? V_W'(gain_sum[V_W+GAIN_SHIFT-1:GAIN_SHIFT]) : '0;
    dz_s     = {m_dz_r, {GUARD_BITS{1'b0}}};
  end

  // --------------------------------------------------------------------------
  // Second CORDIC pass on (|xy|, z - height)
  vec_t          p2_x_r   [NS+1];
  vec_t          p2_y_r   [NS+1];
  turn_t         p2_acc_r [NS+1];
  logic [AW-1:0] p2_pan_r [NS+1];
  logic          p2_nz_r  [NS+1];
  logic          p2_vld_r [NS+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r[0] <= 1'b0;
    end else if (en) begin
      p2_vld_r[0] <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_x_r[0]   <= mag;
      p2_y_r[0]   <= V_W'(dz_s);
      p2_acc_r[0] <= '0;
      p2_pan_r[0] <= m_pan_r;
      p2_nz_r[0]  <= (|mag) || (|m_dz_r);
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_pass2
    vec_t  x_nxt, y_nxt;
    turn_t acc_nxt;

    always_comb begin
      if (!p2_y_r[k][V_W-1]) begin
        x_nxt   = p2_x_r[k] + (p2_y_r[k] >>> k);
        y_nxt   = p2_y_r[k] - (p2_x_r[k] >>> k);
        acc_nxt = p2_acc_r[k] + ATAN_TURNS[k];
      end else begin
        x_nxt   = p2_x_r[k] - (p2_y_r[k] >>> k);
        y_nxt   = p2_y_r[k] + (p2_x_r[k] >>> k);
        acc_nxt = p2_acc_r[k] - ATAN_TURNS[k];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        p2_vld_r[k+1] <= 1'b0;
      end else if (en) begin
        p2_vld_r[k+1] <= p2_vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        p2_x_r[k+1]   <= x_nxt;
        p2_y_r[k+1]   <= y_nxt;
        p2_acc_r[k+1] <= acc_nxt;
        p2_pan_r[k+1] <= p2_pan_r[k];
        p2_nz_r[k+1]  <= p2_nz_r[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tilt rounding and clamp to +-pi/2
  localparam logic signed [AW:0] TMAX = (AW+1)'(1) << (AW-2);

  logic [ACC_W:0]        tilt_sum;
  logic signed [AW:0]    tilt_rnd;
  logic [AW-1:0]         tilt_nxt;
  logic [OUT_W-1:0]      r_word_r;
  logic                  r_vld_r;

  always_comb begin
    tilt_sum = {p2_acc_r[NS][ACC_W-1], p2_acc_r[NS]} + ((ACC_W+1)'(1) << (SH-1));
    tilt_rnd = tilt_sum[ACC_W:SH];
    if (!p2_nz_r[NS]) begin
      tilt_nxt = '0;
    end else if (tilt_rnd > TMAX) begin
      tilt_nxt = TMAX[AW-1:0];
    end else if (tilt_rnd < -TMAX) begin
      tilt_nxt = AW'(-TMAX);
    end else begin
      tilt_nxt = tilt_rnd[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r_vld_r <= 1'b0;
    end else if (en) begin
      r_vld_r <= p2_vld_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_word_r <= OUT_W'({tilt_nxt, p2_pan_r[NS]});
    end
  end

  // --------------------------------------------------------------------------
  // Two-entry output buffer: head drives the port, skid catches one more beat
  logic             out_vld_r;
  logic [OUT_W-1:0] out_data_r;
  logic [OUT_W-1:0] skid_data_r;
  logic             push, pop;

  assign push = en && r_vld_r;
  assign pop  = out_vld_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (pop) begin
        skid_vld_r <= 1'b0;
      end
    end else if (push) begin
      if (out_vld_r && !pop) begin
        skid_vld_r <= 1'b1;
      end
      out_vld_r <= 1'b1;
    end else if (pop) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (out_vld_r && !pop) begin
        skid_data_r <= r_word_r;
      end else begin
        out_data_r <= r_word_r;
      end
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

// File: rtl/core/ptfp_checker.sv
// Port-level checker for pan_tilt_from_position, with its bind.
`default_nettype none

module ptfp_checker #(
  parameter int COORD_WIDTH = 24,
  parameter int ANGLE_WIDTH = 16
) (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_tvalid,
  input wire logic                                 in_tready,
  input wire logic [8*((3*COORD_WIDTH+7)/8)-1:0]   in_tdata,
  input wire logic                                 out_tvalid,
  input wire logic                                 out_tready,
  input wire logic [8*((2*ANGLE_WIDTH+7)/8)-1:0]   out_tdata
);

  localparam int AW = ANGLE_WIDTH;

  logic signed [AW-1:0] tilt;
  logic                 in_beat;

  assign tilt    = out_tdata[2*AW-1:AW];
  assign in_beat = in_tvalid && in_tready && (|in_tdata || !(|in_tdata));

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result beat shown right after reset");

  // Input backpressure only when a result waits and the consumer held it off
  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready) && !in_beat)
    else $error("in_tready dropped without a stalled result");

  // Elevation never leaves +-pi/2
  a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (tilt <= (2**(AW-2))) && (tilt >= -(2**(AW-2))))
    else $error("tilt angle outside +-pi/2");

endmodule

bind pan_tilt_from_position ptfp_checker #(
  .COORD_WIDTH(COORD_WIDTH),
  .ANGLE_WIDTH(ANGLE_WIDTH)
) u_ptfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// File: tb/testbench.sv
// Testbench for pan_tilt_from_position: directed probes, random positions, several mount heights.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_W = 24;
  localparam int ANGLE_W = 16;
  localparam int STEPS = 16;
  localparam int LATENCY = 2 * STEPS + 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int NUM_PHASES = 6;
  localparam int MAX_REPORTS = 40;

  localparam logic signed [COORD_W-1:0] CMAX = 24'sh7FFFFF;
  localparam logic signed [COORD_W-1:0] CMIN = 24'sh800000;
  localparam logic signed [COORD_W-1:0] H_RESET = 24'sd32768;
  localparam longint CMAX_L = 64'sd8388607;
  localparam longint CMIN_L = -64'sd8388608;
  localparam longint TILT_BOUND = 64'sd16384;
  localparam longint GUARD_SCALE = 64'sd65536;
  localparam longint unsigned INV_GAIN_Q32 = 64'd2608131496;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;

  // atan(2^-i) as a fraction of a full turn, 32-bit
  localparam logic [31:0] ATAN_TBL [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  typedef struct packed {
    logic signed [ANGLE_W-1:0] pan;
    logic signed [ANGLE_W-1:0] tilt;
  } angles_t;

  // one position beat and the angles it should produce
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic signed [ANGLE_W-1:0] pan;
    logic signed [ANGLE_W-1:0] tilt;
  } aim_t;

  // directed row: known = 1 means the angles below are taken as typed
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic known;
    logic signed [ANGLE_W-1:0] pan;
    logic signed [ANGLE_W-1:0] tilt;
  } probe_t;

  localparam int NUM_PROBES = 23;
  localparam probe_t PROBES [NUM_PROBES] = '{
    '{x: 24'sd0,      y: 24'sd0,      z: H_RESET,        known: 1'b1, pan: 16'sd0, tilt: 16'sd0},
    '{x: 24'sd0,      y: 24'sd0,      z: 24'sd0,         known: 1'b0, pan: 16'sd0, tilt: 16'sd0},
    '{x: 24'sd0,      y: 24'sd0,      z: CMAX,           known: 1'b0, pan: 16'sd0, tilt: 16'sd0},
    '{x: 24'sd0,      y: 24'sd0,      z: CMIN,           known: 1'b0, pan: 16'sd0, tilt: 16'sd0},
    '{x: CMAX,        y: 24'sd0,      z: H_RESET,        known: 1'b0, pan: 16'sd0, tilt: 16'sd0},
    '{x: CMIN,        y: 24'sd0,      z: H_RESET,        known: 1'b0, pan: 16'sd0, tilt: 16'sd0},
    '{x: 24'sd0,      y: CMAX,        z: H_RESET,        known: 1'b0, pan: 16'sd0, tilt: 16'sd0},
    '{x: 24'sd0,      y: CMIN,        z: H_RESET,        known: 1'b0, pan: 16'sd0, tilt: 16'sd0},
    '{x: CMAX,        y: CMAX,        z: CMAX,           known: 1'b0, pan: 16'sd0, tilt: 16'sd0},
    '{x: CMIN,        y: CMIN,        z: CMIN,           known: 1'b0, pan: 16'sd0, tilt: 16'sd0},
    '{x: CMIN,        y: CMAX,        z: 24'sd0,         known: 1'b0, pan: 16'sd0, tilt: 16'sd0},
    '{x: CMAX,        y: CMIN,        z: 24'sd0,         known: 1'b0, pan: 16'sd0, tilt: 16'sd0},
    '{x: 24'sd1,      y: 24'sd0,      z: H_RESET,        known: 1'b0, pan: 16'sd0, tilt: 16'sd0},
    '{x: -24'sd1,     y: 24'sd0,      z: H_RESET,        known: 1'b0, pan: 16'sd0, tilt: 16'sd0},
    '{x: 24'sd0,      y: 24'sd1,      z: H_RESET,        known: 1'b0, pan: 16'sd0, tilt: 16'sd0},
    '{x: 24'sd0,      y: -24'sd1,     z: H_RESET,        known: 1'b0, pan: 16'sd0, tilt: 16'sd0},
    '{x: -24'sd1,     y: -24'sd1,     z: -24'sd1,        known: 1'b0, pan: 16'sd0, tilt: 16'sd0},
    '{x: 24'sd1,      y: 24'sd1,      z: 24'sd1,         known: 1'b0, pan: 16'sd0, tilt: 16'sd0},
    '{x: 24'sd65536,  y: 24'sd65536,  z: 24'sd98304,     known: 1'b0, pan: 16'sd0, tilt: 16'sd0},
    '{x: -24'sd65536, y: 24'sd1,      z: 24'sd0,         known: 1'b0, pan: 16'sd0, tilt: 16'sd0},
    '{x: -24'sd65536, y: -24'sd1,     z: 24'sd0,         known: 1'b0, pan: 16'sd0, tilt: 16'sd0},
    '{x: CMIN,        y: 24'sd0,      z: CMAX,           known: 1'b0, pan: 16'sd0, tilt: 16'sd0},
    '{x: 24'sd0,      y: 24'sd0,      z: 24'sd32769,     known: 1'b0, pan: 16'sd0, tilt: 16'sd0}
  };

  localparam logic signed [COORD_W-1:0] EDGES [5] = '{CMAX, CMIN, 24'sd0, -24'sd1, 24'sd1};

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [COORD_W-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [3*COORD_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [2*ANGLE_W-1:0] out_tdata;

  logic signed [COORD_W-1:0] cam_height = H_RESET;
  aim_t pending_aims [$];
  int n_errors = 0;
  int n_reports = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit quiet = 1'b0;

  pan_tilt_from_position #(
    .COORD_WIDTH(COORD_W),
    .ANGLE_WIDTH(ANGLE_W),
    .CORDIC_STEPS(STEPS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // CORDIC vectoring: rotate (x, y) onto the x axis, accumulating the turn fraction
  function automatic logic [31:0] cordic_vector(input longint x0, input longint y0,
                                                input logic [31:0] acc0, output longint x_end);
    longint vx, vy, dx, dy;
    logic [31:0] acc;
    vx = x0;
    vy = y0;
    acc = acc0;
    for (int i = 0; i < STEPS && i < 24; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (vy >= 0) begin
        vx = vx + dx;
        vy = vy - dy;
        acc = acc + ATAN_TBL[i];
      end else begin
        vx = vx - dx;
        vy = vy + dy;
        acc = acc - ATAN_TBL[i];
      end
    end
    x_end = vx;
    return acc;
  endfunction

  // turn fraction to a binary angle, round half up
  function automatic longint turn_to_angle(input logic [31:0] acc);
    longint t;
    t = longint'($signed(acc));
    return (t + (64'sd1 <<< (31 - ANGLE_W))) >>> (32 - ANGLE_W);
  endfunction

  function automatic angles_t predict_angles(input logic signed [COORD_W-1:0] x,
                                             input logic signed [COORD_W-1:0] y,
                                             input logic signed [COORD_W-1:0] z,
                                             input logic signed [COORD_W-1:0] h);
    longint dz, vx, vy, x_end, t;
    longint unsigned m, a, b;
    logic [31:0] acc;
    angles_t r;
    dz = longint'(z) - longint'(h);
    if (dz > CMAX_L) dz = CMAX_L;
    if (dz < CMIN_L) dz = CMIN_L;
    r.pan = '0;
    r.tilt = '0;
    m = 0;
    // pan pass on (x, y), then gain compensation of the horizontal magnitude
    if (x != 0 || y != 0) begin
      vx = longint'(x) * GUARD_SCALE;
      vy = longint'(y) * GUARD_SCALE;
      acc = '0;
      if (vx < 0) begin
        vx = -vx;
        vy = -vy;
        acc = HALF_TURN;
      end
      acc = cordic_vector(vx, vy, acc, x_end);
      r.pan = ANGLE_W'(turn_to_angle(acc));
      m = (x_end < 0) ? 64'd0 : x_end;
      a = m >> 22;
      b = m & ((64'd1 << 22) - 64'd1);
      m = (a * INV_GAIN_Q32 + ((b * INV_GAIN_Q32) >> 22)) >> 10;
    end
    // tilt pass on (magnitude, z - height)
    if (m != 0 || dz != 0) begin
      acc = cordic_vector($signed(m), dz * GUARD_SCALE, 32'd0, x_end);
      t = turn_to_angle(acc);
      if (t > TILT_BOUND) t = TILT_BOUND;
      if (t < -TILT_BOUND) t = -TILT_BOUND;
      r.tilt = ANGLE_W'(t);
    end
    return r;
  endfunction

  function automatic logic signed [COORD_W-1:0] pick_coord();
    logic signed [COORD_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = COORD_W'($urandom());
      4, 5:       v = COORD_W'(int'($urandom_range(0, 512)) - 256);
      6:          v = EDGES[$urandom_range(0, 4)];
      7:          v = '0;
      8:          v = COORD_W'(int'($urandom_range(0, 131072)) - 65536);
      default:    v = COORD_W'(int'($urandom_range(0, 2097152)) - 1048576);
    endcase
    return v;
  endfunction

  // sender pacing: random bursts with random gaps, unless in a quiet phase
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!quiet && $urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 8);
        repeat (gap) begin
          @(negedge clk);
          in_tvalid <= 1'b0;
        end
      end
    end
    burst_left--;
  endtask

  // drive one position beat and record its angles once accepted
  task automatic send_position(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y,
                               input logic signed [COORD_W-1:0] z,
                               input logic known,
                               input logic signed [ANGLE_W-1:0] kpan,
                               input logic signed [ANGLE_W-1:0] ktilt);
    angles_t ang;
    aim_t e;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {z, y, x};
    do @(posedge clk); while (!in_tready);
    ang = predict_angles(x, y, z, cam_height);
    e.x = x;
    e.y = y;
    e.z = z;
    e.pan = known ? kpan : ang.pan;
    e.tilt = known ? ktilt : ang.tilt;
    pending_aims.push_back(e);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_aims.size() != 0) @(posedge clk);
  endtask

  task automatic write_height(input logic signed [COORD_W-1:0] h);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= h;
    do @(posedge clk); while (!cfg_ready);
    cam_height = h;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    aim_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_aims.size() == 0) begin
        n_errors++;
        if (n_reports < MAX_REPORTS) begin
          n_reports++;
          $display("%0t unexpected result beat: pan %0d tilt %0d", $time,
                   $signed(out_tdata[ANGLE_W-1:0]), $signed(out_tdata[2*ANGLE_W-1:ANGLE_W]));
        end
      end else begin
        e = pending_aims.pop_front();
        if (out_tdata[ANGLE_W-1:0] !== e.pan) begin
          n_errors++;
          if (n_reports < MAX_REPORTS) begin
            n_reports++;
            $display("%0t pan for (%0d,%0d,%0d): expected %0d actual %0d", $time,
                     e.x, e.y, e.z, e.pan, $signed(out_tdata[ANGLE_W-1:0]));
          end
        end
        if (out_tdata[2*ANGLE_W-1:ANGLE_W] !== e.tilt) begin
          n_errors++;
          if (n_reports < MAX_REPORTS) begin
            n_reports++;
            $display("%0t tilt for (%0d,%0d,%0d): expected %0d actual %0d", $time,
                     e.x, e.y, e.z, e.tilt, $signed(out_tdata[2*ANGLE_W-1:ANGLE_W]));
          end
        end
      end
    end
  end

  // receiver backpressure: switches at random between stall patterns
  rx_mode_e rx_mode = RX_OPEN;
  int rx_left = 0;
  int rx_tick = 0;
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(30, 300);
    end
    rx_left--;
    rx_tick++;
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_COIN:   out_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_tready <= (rx_tick % 4) == 0;
      default:   out_tready <= (rx_tick % 24) >= 16;
    endcase
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic signed [COORD_W-1:0] x, y, z, h;
    int sel;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // directed probes at the reset mount height
    for (int i = 0; i < NUM_PROBES; i++) begin
      pace();
      send_position(PROBES[i].x, PROBES[i].y, PROBES[i].z, PROBES[i].known,
                    PROBES[i].pan, PROBES[i].tilt);
    end

    // random phases; every phase but the first starts by writing a mount height
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       h = cam_height;
        1:       h = CMIN;
        2:       h = CMAX;
        3:       h = '0;
        4:       h = COORD_W'($urandom());
        default: h = H_RESET;
      endcase
      if (ph > 0) write_height(h);
      quiet = (ph == 3);
      // both-zero case and z saturation at this height
      send_position('0, '0, cam_height, 1'b1, '0, '0);
      send_position(pick_coord(), pick_coord(), CMAX, 1'b0, '0, '0);
      send_position(pick_coord(), pick_coord(), CMIN, 1'b0, '0, '0);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        pace();
        if (ph == 2 && k == ITEMS_PER_PHASE / 2) drain();
        x = pick_coord();
        y = pick_coord();
        z = pick_coord();
        sel = $urandom_range(0, 99);
        if (sel < 5) begin
          x = '0;
          y = '0;
          if (sel < 2) z = cam_height;
        end
        send_position(x, y, z, 1'b0, '0, '0);
      end
    end

    drain();
    repeat (LATENCY + 4) @(posedge clk);
    if (n_errors == 0 && pending_aims.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
